// ----- rtl/normal_map_tangent_frame_defines.svh -----
// Assertion macros for the tangent frame normal mapping block.
`ifndef NORMAL_MAP_TANGENT_FRAME_DEFINES_SVH
`define NORMAL_MAP_TANGENT_FRAME_DEFINES_SVH
`ifndef SYNTH
// Check on every clock edge out of reset.
`define NMTF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("normal_map_tangent_frame assertion failed");
// Check on every clock edge, reset included.
`define NMTF_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("normal_map_tangent_frame assertion failed");
`else
`define NMTF_ASSERT(lbl, prop)
`define NMTF_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/nmtf_pkg.sv -----
// Word types for the tangent frame normal mapping block.
package nmtf_pkg;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [15:0] map_x;
		logic signed [15:0] map_y;
		logic signed [15:0] map_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} vec_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic               degenerate;
	} res_t;

	localparam int SQRT_STAGES = 16;
	localparam logic signed [63:0] P_LIMIT = 64'sd2147483647;

endpackage

// ----- rtl/normal_map_tangent_frame.sv -----
// Tangent frame normal mapping: projection, normalize, cross product, basis change.
//
//   channel | signals                          | word
//   --------+----------------------------------+-----------------
//   input   | vec_valid, vec_ready, vec        | nmtf_pkg::vec_t
//   output  | res_valid, res_ready, res        | nmtf_pkg::res_t
//
// One word enters per cycle unless a full pipeline holds on a stalled output.
// Depth is set by the square root, two result bits per stage over 16 stages, and
// the three-lane divider, two quotient bits per stage.
// Each stage holds when its successor is full and stalled; bubbles close up.
// Reset clears the valid bits only; the pipeline comes out of reset empty.
`include "normal_map_tangent_frame_defines.svh"

module normal_map_tangent_frame #(
	parameter int FRAC_BITS = 14
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vec_valid,
	output logic           vec_ready,
	input  nmtf_pkg::vec_t vec,
	output logic           res_valid,
	input  logic           res_ready,
	output nmtf_pkg::res_t res
);

	localparam int F   = FRAC_BITS;
	localparam int DW  = 34 - F;
	localparam int NDW = 16 + DW;
	localparam int QW  = F + 1;
	localparam int BW  = F + 2;
	localparam int PW  = 16 + BW;
	localparam int CW  = 18;
	localparam int NSQ = nmtf_pkg::SQRT_STAGES;
	localparam int NDV = (F + 2) / 2;

	localparam int S_PROD = 0;
	localparam int S_DOT  = 1;
	localparam int S_ND   = 2;
	localparam int S_P    = 3;
	localparam int S_SQ   = 4;
	localparam int S_SUM  = 5;
	localparam int SQ0    = 6;
	localparam int DP     = SQ0 + NSQ;
	localparam int DV0    = DP + 1;
	localparam int SB     = DV0 + NDV;
	localparam int SXP    = SB + 1;
	localparam int SC     = SXP + 1;
	localparam int SMP    = SC + 1;
	localparam int SOUT   = SMP + 1;
	localparam int NST    = SOUT + 1;

	localparam logic signed [63:0] HALF  = 64'sd1 <<< (F - 1);
	localparam logic signed [BW-1:0] B_MAX = BW'(64'sd1 <<< F);

	typedef struct packed {
		nmtf_pkg::vec_t        v;
		logic [2:0][31:0]      p;
		logic [31:0]           len;
		logic                  deg;
		logic [2:0][BW-1:0]    b;
	} cry_t;

	function automatic logic signed [15:0] nrm_at(input nmtf_pkg::vec_t v, input logic [1:0] i);
		unique case (i)
			2'd0:    return v.normal_x;
			2'd1:    return v.normal_y;
			default: return v.normal_z;
		endcase
	endfunction

	function automatic logic signed [15:0] map_at(input nmtf_pkg::vec_t v, input logic [1:0] i);
		unique case (i)
			2'd0:    return v.map_x;
			2'd1:    return v.map_y;
			default: return v.map_z;
		endcase
	endfunction

	function automatic logic signed [15:0] dir_at(input nmtf_pkg::vec_t v, input logic [1:0] i);
		unique case (i)
			2'd0:    return v.dir_x;
			2'd1:    return v.dir_y;
			default: return v.dir_z;
		endcase
	endfunction

	logic [NST-1:0] vld_s;
	logic [NST-1:0] en;
	cry_t           cry_s [NST];
	cry_t           cry_d [NST];

	logic signed [31:0]    nu_s1 [3];
	logic signed [DW-1:0]  d_s2;
	logic signed [NDW-1:0] nd_s3 [3];
	logic [61:0]           pp_s5 [3];
	logic [63:0]           sq_v_s [NSQ+1];
	logic [63:0]           sq_r_s [NSQ+1];
	logic [31:0]           dv_rem_s [NDV+1][3];
	logic [QW-1:0]         dv_low_s [NDV+1][3];
	logic [QW-1:0]         dv_q_s [NDV+1][3];
	logic signed [PW-1:0]  xp_s [6];
	logic signed [CW-1:0]  c_s [3];
	logic signed [PW-1:0]  mb_s [3];
	logic signed [33:0]    mc_s [3];
	logic signed [31:0]    mn_s [3];
	nmtf_pkg::res_t        res_s;

	logic signed [31:0]    nu_c [3];
	logic signed [DW-1:0]  d_c;
	logic signed [NDW-1:0] nd_c [3];
	logic [31:0]           p_c [3];
	logic [61:0]           pp_c [3];
	logic [63:0]           len2_c;
	logic [31:0]           len_c;
	logic [31:0]           rem0_c [3];
	logic [QW-1:0]         low0_c [3];
	logic [BW-1:0]         b_c [3];
	logic signed [PW-1:0]  xp_c [6];
	logic signed [CW-1:0]  c_c [3];
	logic signed [PW-1:0]  mb_c [3];
	logic signed [33:0]    mc_c [3];
	logic signed [31:0]    mn_c [3];
	nmtf_pkg::res_t        res_c;

	// Stage advances when empty or when the next one advances.
	always_comb begin
		en[NST-1] = !vld_s[NST-1] || res_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign vec_ready = en[0];
	assign res_valid = vld_s[NST-1];
	assign res       = res_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= vec_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// Front: dot product, projection, square sum.
	always_comb begin
		logic signed [63:0] t;
		logic signed [63:0] raw;
		logic signed [63:0] sq;
		for (int i = 0; i < 3; i++) begin
			nu_c[i] = nrm_at(vec, 2'(i)) * dir_at(vec, 2'(i));
		end
		t = 64'(nu_s1[0]) + 64'(nu_s1[1]) + 64'(nu_s1[2]) + HALF;
		d_c = DW'(t >>> F);
		for (int i = 0; i < 3; i++) begin
			nd_c[i] = nrm_at(cry_s[S_DOT].v, 2'(i)) * d_s2;
		end
		for (int i = 0; i < 3; i++) begin
			raw = (64'(dir_at(cry_s[S_ND].v, 2'(i))) <<< F) - 64'(nd_s3[i]);
			raw = (raw + HALF) >>> F;
			if (raw > nmtf_pkg::P_LIMIT) begin
				p_c[i] = 32'(nmtf_pkg::P_LIMIT);
			end else if (raw < -nmtf_pkg::P_LIMIT) begin
				p_c[i] = 32'(-nmtf_pkg::P_LIMIT);
			end else begin
				p_c[i] = 32'(raw);
			end
		end
		for (int i = 0; i < 3; i++) begin
			sq = 64'($signed(cry_s[S_P].p[i])) * 64'($signed(cry_s[S_P].p[i]));
			pp_c[i] = sq[61:0];
		end
		len2_c = 64'(pp_s5[0]) + 64'(pp_s5[1]) + 64'(pp_s5[2]);
	end

	// Divider setup: numerator |p| * 2^F + len / 2, split into top and shifted-in bits.
	always_comb begin
		logic [63:0] num;
		logic [31:0] mag;
		len_c = sq_r_s[NSQ][31:0];
		for (int i = 0; i < 3; i++) begin
			mag = cry_s[DP-1].p[i][31] ? 32'(-$signed(cry_s[DP-1].p[i])) : cry_s[DP-1].p[i];
			num = (64'(mag) << F) + 64'(len_c >> 1);
			rem0_c[i] = 32'(num >> QW);
			low0_c[i] = num[QW-1:0];
		end
	end

	// Back: sign, cross product, basis change, saturation, zeroing of degenerate words.
	always_comb begin
		logic signed [63:0] t;
		logic signed [BW-1:0] bv [3];
		for (int i = 0; i < 3; i++) begin
			b_c[i] = cry_s[SB-1].p[i][31] ? BW'(-$signed({1'b0, dv_q_s[NDV][i]}))
			                              : BW'({1'b0, dv_q_s[NDV][i]});
		end
		for (int i = 0; i < 3; i++) begin
			bv[i] = $signed(cry_s[SB].b[i]);
		end
		xp_c[0] = cry_s[SB].v.normal_y * bv[2];
		xp_c[1] = cry_s[SB].v.normal_z * bv[1];
		xp_c[2] = cry_s[SB].v.normal_z * bv[0];
		xp_c[3] = cry_s[SB].v.normal_x * bv[2];
		xp_c[4] = cry_s[SB].v.normal_x * bv[1];
		xp_c[5] = cry_s[SB].v.normal_y * bv[0];
		for (int i = 0; i < 3; i++) begin
			t = 64'(xp_s[2*i]) - 64'(xp_s[2*i+1]) + HALF;
			c_c[i] = CW'(t >>> F);
		end
		for (int i = 0; i < 3; i++) begin
			mb_c[i] = cry_s[SC].v.map_x * $signed(cry_s[SC].b[i]);
			mc_c[i] = cry_s[SC].v.map_y * c_s[i];
			mn_c[i] = cry_s[SC].v.map_z * nrm_at(cry_s[SC].v, 2'(i));
		end
		res_c = '0;
		res_c.degenerate = cry_s[SMP].deg;
		for (int i = 0; i < 3; i++) begin
			logic signed [15:0] r;
			t = (64'(mb_s[i]) + 64'(mc_s[i]) + 64'(mn_s[i]) + HALF) >>> F;
			if (t > 64'sd32767) begin
				r = 16'sh7FFF;
			end else if (t < -64'sd32768) begin
				r = 16'sh8000;
			end else begin
				r = 16'(t);
			end
			if (cry_s[SMP].deg) begin
				r = '0;
			end
			unique case (i)
				0:       res_c.out_x = r;
				1:       res_c.out_y = r;
				default: res_c.out_z = r;
			endcase
		end
	end

	// Side data rides along; selected stages drop their results into it.
	always_comb begin
		cry_d[0]   = '0;
		cry_d[0].v = vec;
		for (int k = 1; k < NST; k++) begin
			cry_d[k] = cry_s[k-1];
		end
		for (int i = 0; i < 3; i++) begin
			cry_d[S_P].p[i] = p_c[i];
			cry_d[SB].b[i]  = b_c[i];
		end
		cry_d[DP].len = len_c;
		cry_d[DP].deg = (len_c == 32'd0);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NST; k++) begin
			if (en[k]) begin
				cry_s[k] <= cry_d[k];
			end
		end
		if (en[S_PROD]) begin
			nu_s1 <= nu_c;
		end
		if (en[S_DOT]) begin
			d_s2 <= d_c;
		end
		if (en[S_ND]) begin
			nd_s3 <= nd_c;
		end
		if (en[S_SQ]) begin
			pp_s5 <= pp_c;
		end
		if (en[S_SUM]) begin
			sq_v_s[0] <= len2_c;
			sq_r_s[0] <= '0;
		end
		if (en[DP]) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= rem0_c[i];
				dv_low_s[0][i] <= low0_c[i];
				dv_q_s[0][i]   <= '0;
			end
		end
		if (en[SXP]) begin
			xp_s <= xp_c;
		end
		if (en[SC]) begin
			c_s <= c_c;
		end
		if (en[SMP]) begin
			mb_s <= mb_c;
			mc_s <= mc_c;
			mn_s <= mn_c;
		end
		if (en[SOUT]) begin
			res_s <= res_c;
		end
	end

	// Square root, two result bits per stage.
	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		logic [63:0] v_c;
		logic [63:0] r_c;
		always_comb begin
			logic [63:0] bitv;
			v_c = sq_v_s[k];
			r_c = sq_r_s[k];
			for (int t = 0; t < 2; t++) begin
				bitv = 64'd1 << (62 - 2 * (2 * k + t));
				if (v_c >= r_c + bitv) begin
					v_c = v_c - (r_c + bitv);
					r_c = (r_c >> 1) + bitv;
				end else begin
					r_c = r_c >> 1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[SQ0+k]) begin
				sq_v_s[k+1] <= v_c;
				sq_r_s[k+1] <= r_c;
			end
		end
	end

	// Restoring divide by len, three lanes, two quotient bits per stage.
	for (genvar k = 0; k < NDV; k++) begin : g_div
		logic [31:0]   rem_c [3];
		logic [QW-1:0] low_c [3];
		logic [QW-1:0] q_c [3];
		always_comb begin
			logic [32:0] tt;
			for (int i = 0; i < 3; i++) begin
				rem_c[i] = dv_rem_s[k][i];
				low_c[i] = dv_low_s[k][i];
				q_c[i]   = dv_q_s[k][i];
				for (int t = 0; t < 2; t++) begin
					if (2 * k + t < QW) begin
						tt = {rem_c[i], low_c[i][QW-1]};
						low_c[i] = low_c[i] << 1;
						if (tt >= {1'b0, cry_s[DV0+k-1].len}) begin
							tt = tt - {1'b0, cry_s[DV0+k-1].len};
							q_c[i] = {q_c[i][QW-2:0], 1'b1};
						end else begin
							q_c[i] = {q_c[i][QW-2:0], 1'b0};
						end
						rem_c[i] = tt[31:0];
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[DV0+k]) begin
				dv_rem_s[k+1] <= rem_c;
				dv_low_s[k+1] <= low_c;
				dv_q_s[k+1]   <= q_c;
			end
		end
	end

	`NMTF_ASSERT(a_enter, vec_valid && vec_ready |=> vld_s[0])
	`NMTF_ASSERT(a_hold, vld_s[DP] && !en[DP] |=> vld_s[DP] && $stable(cry_s[DP].len))
	`NMTF_ASSERT(a_b_hi, vld_s[SB] && !cry_s[SB].deg |-> $signed(cry_s[SB].b[0]) <= B_MAX)
	`NMTF_ASSERT(a_b_lo, vld_s[SB] && !cry_s[SB].deg |-> $signed(cry_s[SB].b[0]) >= -B_MAX)
	`NMTF_ASSERT_ALWAYS(a_deg, res_valid && res.degenerate |-> res.out_x == 16'sd0 && res.out_z == 16'sd0)

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the tangent frame normal mapping block: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

class frame_scoreboard;
	nmtf_pkg::res_t pending[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	// round half up, then floor-divide by 2^sh
	function longint rnd_shift(longint v, int sh);
		longint t;
		t = v + (64'sd1 <<< (sh - 1));
		return t >>> sh;
	endfunction

	function longint clamp(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function longint unsigned int_sqrt(longint unsigned v);
		longint unsigned acc, bitv;
		acc = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= acc + bitv) begin
				v -= acc + bitv;
				acc = (acc >> 1) + bitv;
			end else begin
				acc >>= 1;
			end
			bitv >>= 2;
		end
		return acc;
	endfunction

	function longint div_round(longint a, longint unsigned d);
		longint unsigned mag, q;
		mag = (a < 0) ? longint'(-a) : a;
		q = (mag + d / 2) / d;
		return (a < 0) ? -longint'(q) : longint'(q);
	endfunction

	function nmtf_pkg::res_t frame_transform(nmtf_pkg::vec_t w);
		nmtf_pkg::res_t r;
		longint n[3], m[3], u[3], p[3], b[3], c[3], o[3];
		longint dot, raw;
		longint unsigned sq, len;
		n = '{w.normal_x, w.normal_y, w.normal_z};
		m = '{w.map_x, w.map_y, w.map_z};
		u = '{w.dir_x, w.dir_y, w.dir_z};
		dot = rnd_shift(n[0] * u[0] + n[1] * u[1] + n[2] * u[2], 14);
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			raw = (u[i] <<< 14) - n[i] * dot;
			p[i] = clamp(rnd_shift(raw, 14), 64'sd2147483647);
			sq += longint'(p[i] * p[i]);
		end
		len = int_sqrt(sq);
		r = '0;
		if (len == 0) begin
			r.degenerate = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) b[i] = div_round(p[i] <<< 14, len);
		c[0] = rnd_shift(n[1] * b[2] - n[2] * b[1], 14);
		c[1] = rnd_shift(n[2] * b[0] - n[0] * b[2], 14);
		c[2] = rnd_shift(n[0] * b[1] - n[1] * b[0], 14);
		for (int i = 0; i < 3; i++) begin
			o[i] = rnd_shift(m[0] * b[i] + m[1] * c[i] + m[2] * n[i], 14);
			if (o[i] > 32767) o[i] = 32767;
			if (o[i] < -32768) o[i] = -32768;
		end
		r.out_x = o[0][15:0];
		r.out_y = o[1][15:0];
		r.out_z = o[2][15:0];
		return r;
	endfunction

	function void note_word(nmtf_pkg::vec_t w);
		pending.push_back(frame_transform(w));
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	task check_word(nmtf_pkg::res_t got);
		nmtf_pkg::res_t want;
		if (pending.size() == 0) begin
			$display("unexpected result word at %0t", $time);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
		if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
		if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
		if (got.degenerate !== want.degenerate)
			report("degenerate", got.degenerate, want.degenerate);
	endtask
endclass

module tb_top;
	logic clk, arst_n;
	logic vec_valid, vec_ready, res_valid, res_ready;
	nmtf_pkg::vec_t vec;
	nmtf_pkg::res_t res;
	frame_scoreboard sb;
	bit quiet;

	normal_map_tangent_frame uut (
		.clk(clk), .arst_n(arst_n),
		.vec_valid(vec_valid), .vec_ready(vec_ready), .vec(vec),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

	// sample words on the edge, before the driver's nonblocking updates land
	always @(posedge clk) begin
		if (arst_n && vec_valid && vec_ready) sb.note_word(vec);
		if (arst_n && res_valid && res_ready) sb.check_word(res);
	end

	// receiver stalls in bursts
	initial begin
		int gap;
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 7);
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	task automatic send_word(nmtf_pkg::vec_t w);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 7);
			vec_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vec_valid <= 1'b1;
		vec <= w;
		@(posedge clk);
		while (!vec_ready) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_comp();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h4000;
			3: return 16'hc000;
			4: return 16'(int'($urandom_range(0, 32768)) - 16384);
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic send_directed();
		nmtf_pkg::vec_t w;
		logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		for (int i = 0; i < 4; i++) begin
			w = {9{ext[i]}};
			send_word(w);
		end
		// zero direction, direction along the normal, unit axes
		w = '0; w.normal_z = 16'sd16384; w.map_z = 16'sd16384;
		send_word(w);
		w.dir_z = 16'sd16384; send_word(w);
		w.dir_z = -16'sd8192; send_word(w);
		w.dir_z = '0; w.dir_x = 16'sd16384; w.map_x = 16'sd16384; send_word(w);
		w.map_y = 16'sd16384; send_word(w);
		w.map_x = 16'h7fff; w.map_y = 16'h7fff; w.map_z = 16'h7fff; send_word(w);
		w.map_x = 16'h8000; w.map_y = 16'h8000; w.map_z = 16'h8000; send_word(w);
		// non-unit normal
		w.normal_x = 16'h7fff; w.normal_y = 16'h8000; w.dir_y = 16'h7fff; send_word(w);
		w = '0; w.dir_y = 16'sd1; send_word(w);
		w.normal_y = 16'sd16384; send_word(w);
	endtask

	function automatic nmtf_pkg::vec_t random_word();
		nmtf_pkg::vec_t w;
		if ($urandom_range(0, 3) == 0) begin
			w = 144'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
		end else begin
			w.normal_x = pick_comp(); w.normal_y = pick_comp(); w.normal_z = pick_comp();
			w.map_x = pick_comp(); w.map_y = pick_comp(); w.map_z = pick_comp();
			w.dir_x = pick_comp(); w.dir_y = pick_comp(); w.dir_z = pick_comp();
			// occasionally point the direction along the normal
			if ($urandom_range(0, 9) == 0) begin
				w.dir_x = w.normal_x; w.dir_y = w.normal_y; w.dir_z = w.normal_z;
			end
		end
		return w;
	endfunction

	initial begin
		sb = new();
		quiet = 0;
		arst_n = 1'b0;
		vec_valid = 1'b0;
		vec = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		for (int i = 0; i < 900; i++) begin
			if (i == 750) quiet = 1;
			send_word(random_word());
		end
		vec_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
